// ===== hw/rtl/fud_pkg.sv =====
// shared types, constants and helpers of the form body decoder
package fud_pkg;

  localparam int unsigned PairCountMaxDefault = 256;
  localparam int unsigned BudgetMaxDefault    = 65535;

  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MaxPairsW = 9;
  localparam int unsigned BudgetW   = 16;

  localparam logic [MaxPairsW-1:0] MaxPairsReset = 9'd16;
  localparam logic [BudgetW-1:0]   BudgetReset   = 16'd4096;

  localparam logic [CfgIdxW-1:0] CFG_MAX_PAIRS   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BYTE_BUDGET = 2'd1;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3d;
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UP_A    = 8'h41;
  localparam logic [7:0] CHAR_UP_F    = 8'h46;
  localparam logic [7:0] CHAR_LO_A    = 8'h61;
  localparam logic [7:0] CHAR_LO_F    = 8'h66;
  localparam logic [7:0] HEX_TEN      = 8'd10;

  typedef enum logic [2:0] {
    MODE_KEY   = 3'b001,
    MODE_VALUE = 3'b010,
    MODE_STOP  = 3'b100
  } mode_e;

  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_HIGH = 3'b010,
    ESC_LOW  = 3'b100
  } esc_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_EQUALS  = 3'd1,
    ST_EQUALS_END = 3'd2,
    ST_ESC_CUT    = 3'd3,
    ST_BAD_HEX    = 3'd4,
    ST_BUDGET     = 3'd5,
    ST_PAIR_LIMIT = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_is_value;
    logic       field_end;
    logic       pair_end;
    logic       body_end;
    status_e    status;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t       h;
    logic [7:0] t;
    h = '0;
    t = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = c - CHAR_ZERO;
      h.ok = 1'b1;
    end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
      t = c - CHAR_UP_A + HEX_TEN;
      h.ok = 1'b1;
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
      t = c - CHAR_LO_A + HEX_TEN;
      h.ok = 1'b1;
    end
    h.nibble = t[3:0];
    return h;
  endfunction

endpackage

// ===== hw/rtl/fud_step.sv =====
// next-state and result logic for one body byte
module fud_step #(
  parameter int unsigned PW = 9,
  parameter int unsigned BW = 16
) (
  input  logic [7:0]       in_byte_i,
  input  logic             last_byte_i,
  input  logic [PW-1:0]    limit_i,
  input  logic [BW-1:0]    budget_i,
  input  fud_pkg::mode_e   mode_i,
  input  fud_pkg::esc_e    esc_i,
  input  logic [3:0]       nib_i,
  input  logic [PW-1:0]    pairs_i,
  input  logic [BW-1:0]    bytes_i,
  output fud_pkg::mode_e   mode_o,
  output fud_pkg::esc_e    esc_o,
  output logic [3:0]       nib_o,
  output logic [PW-1:0]    pairs_o,
  output logic [BW-1:0]    bytes_o,
  output logic             res_en_o,
  output fud_pkg::result_t res_o
);

  fud_pkg::hex_t    hv;
  logic             fail_en;
  fud_pkg::status_e fail_code;
  logic             data_en;
  logic [7:0]       data;
  logic             rearm;
  logic [BW:0]      need_one;
  logic [BW:0]      need_two;
  logic [BW:0]      budget_ext;

  assign hv         = fud_pkg::hex_value(in_byte_i);
  assign need_one   = {1'b0, bytes_i} + {{BW{1'b0}}, 1'b1};
  assign need_two   = {1'b0, bytes_i} + (BW + 1)'(2);
  assign budget_ext = {1'b0, budget_i};

  always_comb begin
    mode_o    = mode_i;
    esc_o     = esc_i;
    nib_o     = nib_i;
    pairs_o   = pairs_i;
    bytes_o   = bytes_i;
    res_en_o  = 1'b0;
    res_o     = '0;
    fail_en   = 1'b0;
    fail_code = fud_pkg::ST_OK;
    data_en   = 1'b0;
    data      = '0;
    rearm     = 1'b0;

    if (mode_i == fud_pkg::MODE_STOP) begin
      rearm = last_byte_i;
    end else if (mode_i == fud_pkg::MODE_KEY && pairs_i >= limit_i) begin
      fail_en   = 1'b1;
      fail_code = fud_pkg::ST_PAIR_LIMIT;
    end else begin
      unique case (esc_i)
        fud_pkg::ESC_HIGH: begin
          if (last_byte_i) begin
            fail_en   = 1'b1;
            fail_code = fud_pkg::ST_ESC_CUT;
          end else if (!hv.ok) begin
            fail_en   = 1'b1;
            fail_code = fud_pkg::ST_BAD_HEX;
          end else begin
            nib_o = hv.nibble;
            esc_o = fud_pkg::ESC_LOW;
          end
        end
        fud_pkg::ESC_LOW: begin
          if (!hv.ok) begin
            fail_en   = 1'b1;
            fail_code = fud_pkg::ST_BAD_HEX;
          end else begin
            data    = {nib_i, hv.nibble};
            data_en = 1'b1;
            esc_o   = fud_pkg::ESC_IDLE;
            nib_o   = '0;
          end
        end
        default: begin
          if (in_byte_i == fud_pkg::CHAR_PERCENT) begin
            if (last_byte_i) begin
              fail_en   = 1'b1;
              fail_code = fud_pkg::ST_ESC_CUT;
            end else begin
              esc_o = fud_pkg::ESC_HIGH;
            end
          end else if (in_byte_i == fud_pkg::CHAR_EQUALS && mode_i == fud_pkg::MODE_KEY) begin
            if (last_byte_i) begin
              fail_en   = 1'b1;
              fail_code = fud_pkg::ST_EQUALS_END;
            end else if (need_one > budget_ext) begin
              fail_en   = 1'b1;
              fail_code = fud_pkg::ST_BUDGET;
            end else begin
              bytes_o         = need_one[BW-1:0];
              res_en_o        = 1'b1;
              res_o.field_end = 1'b1;
              mode_o          = fud_pkg::MODE_VALUE;
            end
          end else if (in_byte_i == fud_pkg::CHAR_AMP) begin
            if (mode_i == fud_pkg::MODE_KEY) begin
              fail_en   = 1'b1;
              fail_code = fud_pkg::ST_NO_EQUALS;
            end else if (need_one > budget_ext) begin
              fail_en   = 1'b1;
              fail_code = fud_pkg::ST_BUDGET;
            end else begin
              bytes_o            = need_one[BW-1:0];
              pairs_o            = pairs_i + {{(PW-1){1'b0}}, 1'b1};
              res_en_o           = 1'b1;
              res_o.out_is_value = 1'b1;
              res_o.field_end    = 1'b1;
              res_o.pair_end     = 1'b1;
              res_o.body_end     = last_byte_i;
              mode_o             = fud_pkg::MODE_KEY;
              rearm              = last_byte_i;
            end
          end else begin
            data    = in_byte_i;
            data_en = 1'b1;
          end
        end
      endcase

      if (data_en) begin
        if (mode_i == fud_pkg::MODE_KEY && last_byte_i) begin
          fail_en   = 1'b1;
          fail_code = fud_pkg::ST_NO_EQUALS;
        end else if (need_two > budget_ext) begin
          fail_en   = 1'b1;
          fail_code = fud_pkg::ST_BUDGET;
        end else begin
          bytes_o            = last_byte_i ? need_two[BW-1:0] : need_one[BW-1:0];
          res_en_o           = 1'b1;
          res_o.out_byte     = data;
          res_o.out_valid    = 1'b1;
          res_o.out_is_value = (mode_i == fud_pkg::MODE_VALUE);
          res_o.field_end    = last_byte_i;
          res_o.pair_end     = last_byte_i;
          res_o.body_end     = last_byte_i;
          rearm              = last_byte_i;
        end
      end
    end

    if (fail_en) begin
      res_en_o       = 1'b1;
      res_o          = '0;
      res_o.status   = fail_code;
      res_o.body_end = last_byte_i;
      if (last_byte_i) begin
        rearm = 1'b1;
      end else begin
        mode_o = fud_pkg::MODE_STOP;
      end
    end

    if (rearm) begin
      mode_o  = fud_pkg::MODE_KEY;
      esc_o   = fud_pkg::ESC_IDLE;
      nib_o   = '0;
      pairs_o = '0;
      bytes_o = '0;
    end
  end

endmodule

// ===== hw/rtl/form_urlencoded_decoder.sv =====
// form body decoder top level: config, parse state and result register
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_byte_i, last_byte_i
//   result   output     res_valid_o / res_ready_i out_byte_o .. status_o
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one byte per cycle unless stalled; a byte's result is in the register
// the cycle after its transaction; bytes giving no result only update state.
// the parse state and the result register are the only loop: a new byte is
// taken whenever the result register is empty or being drained this cycle.
// reset returns the parse state to key mode and the registers to 16 / 4096.
// a stalled result holds in_ready_o low until it is taken.
module form_urlencoded_decoder #(
  parameter int unsigned PAIR_COUNT_MAX = fud_pkg::PairCountMaxDefault,
  parameter int unsigned BUDGET_MAX     = fud_pkg::BudgetMaxDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fud_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fud_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   in_byte_i,
  input  logic                         last_byte_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [7:0]                   out_byte_o,
  output logic                         out_valid_o,
  output logic                         out_is_value_o,
  output logic                         field_end_o,
  output logic                         pair_end_o,
  output logic                         body_end_o,
  output logic [2:0]                   status_o
);

  localparam int unsigned PW   = $clog2(PAIR_COUNT_MAX + 1);
  localparam int unsigned BW   = $clog2(BUDGET_MAX + 1);
  localparam int unsigned LimW = (PW > fud_pkg::MaxPairsW) ? PW : fud_pkg::MaxPairsW;
  localparam int unsigned BudW = (BW > fud_pkg::BudgetW) ? BW : fud_pkg::BudgetW;

  logic [fud_pkg::MaxPairsW-1:0] max_pairs_q;
  logic [fud_pkg::BudgetW-1:0]   budget_q;

  fud_pkg::mode_e   mode_q, mode_d;
  fud_pkg::esc_e    esc_q, esc_d;
  logic [3:0]       nib_q, nib_d;
  logic [PW-1:0]    pairs_q, pairs_d;
  logic [BW-1:0]    bytes_q, bytes_d;

  logic             res_vld_q;
  fud_pkg::result_t res_q;
  fud_pkg::result_t res_d;
  logic             res_en;

  logic [LimW-1:0]  limit_full;
  logic [BudW-1:0]  budget_full;
  logic [PW-1:0]    limit;
  logic [BW-1:0]    budget;
  logic             in_fire;

  assign limit_full  = (LimW'(max_pairs_q) < LimW'(PAIR_COUNT_MAX)) ?
                       LimW'(max_pairs_q) : LimW'(PAIR_COUNT_MAX);
  assign budget_full = (BudW'(budget_q) < BudW'(BUDGET_MAX)) ?
                       BudW'(budget_q) : BudW'(BUDGET_MAX);
  assign limit       = limit_full[PW-1:0];
  assign budget      = budget_full[BW-1:0];

  assign in_ready_o = !res_vld_q || res_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  fud_step #(
    .PW (PW),
    .BW (BW)
  ) u_step (
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .limit_i     (limit),
    .budget_i    (budget),
    .mode_i      (mode_q),
    .esc_i       (esc_q),
    .nib_i       (nib_q),
    .pairs_i     (pairs_q),
    .bytes_i     (bytes_q),
    .mode_o      (mode_d),
    .esc_o       (esc_d),
    .nib_o       (nib_d),
    .pairs_o     (pairs_d),
    .bytes_o     (bytes_d),
    .res_en_o    (res_en),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pairs_q <= fud_pkg::MaxPairsReset;
      budget_q    <= fud_pkg::BudgetReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fud_pkg::CFG_MAX_PAIRS) begin
        max_pairs_q <= cfg_wdata_i[fud_pkg::MaxPairsW-1:0];
      end else if (cfg_idx_i == fud_pkg::CFG_BYTE_BUDGET) begin
        budget_q <= cfg_wdata_i[fud_pkg::BudgetW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= fud_pkg::MODE_KEY;
      esc_q   <= fud_pkg::ESC_IDLE;
      nib_q   <= '0;
      pairs_q <= '0;
      bytes_q <= '0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      esc_q   <= esc_d;
      nib_q   <= nib_d;
      pairs_q <= pairs_d;
      bytes_q <= bytes_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (in_fire) begin
      res_vld_q <= res_en;
    end else if (res_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_en) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o    = res_vld_q;
  assign out_byte_o     = res_q.out_byte;
  assign out_valid_o    = res_q.out_valid;
  assign out_is_value_o = res_q.out_is_value;
  assign field_end_o    = res_q.field_end;
  assign pair_end_o     = res_q.pair_end;
  assign body_end_o     = res_q.body_end;
  assign status_o       = res_q.status;

endmodule
